// ===== hw/rtl/shtb_pkg.sv =====
package shtb_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 40;

    localparam logic signed [15:0] INITIAL_ROOM_TEMP_DEF = 16'sd5120;

    localparam logic [55:0] K_NUM       = 56'd27778;
    localparam logic [63:0] FIVE_POW_11 = 64'd48828125;
    localparam logic [63:0] LOSS_DIV    = 64'd256000;
    localparam logic [63:0] Q16_ONE     = 64'd65536;
    localparam logic [63:0] MAG_CAP     = 64'h4000_0000_0000_0000;

    localparam logic [3:0] SH_NONE  = 4'd0;
    localparam logic [3:0] SH_TERM  = 4'd3;
    localparam logic [3:0] SH_DTEMP = 4'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WALL_G    = 4'd0,
        REG_AIR_CAP   = 4'd1,
        REG_H2_MIN    = 4'd2,
        REG_H2_MAX    = 4'd3,
        REG_BAT_MIN   = 4'd4,
        REG_BAT_MAX   = 4'd5,
        REG_XFER_EFF  = 4'd6,
        REG_HEAT_EFF  = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic       start;
        logic       mul_only;
        logic [3:0] shift;
    } md_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/shtb_muldiv.sv =====
module shtb_muldiv import shtb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  md_req_t            req,
    input  logic signed [63:0] op_a,
    input  logic        [63:0] op_b,
    input  logic        [63:0] op_c,
    output logic               done,
    output logic signed [63:0] result
);

    typedef enum logic [2:0] {U_IDLE, U_MUL, U_CHK, U_DIV, U_POST} ustate_t;

    ustate_t            state_reg;
    logic [5:0]         cnt_reg;
    logic [127:0]       p_reg;
    logic [63:0]        a_reg;
    logic [63:0]        c_reg;
    logic               neg_reg;
    logic               mul_only_reg;
    logic [3:0]         sh_reg;
    logic               ovf_reg;
    logic               done_reg;
    logic signed [63:0] result_reg;

    logic [64:0]  mul_sum;
    logic [64:0]  rtop;
    logic [64:0]  rdiff;
    logic         ge;
    logic [127:0] div_step;
    logic [63:0]  quo;
    logic [63:0]  mag;
    logic [63:0]  capped;

    always_comb begin
        mul_sum  = {1'b0, p_reg[127:64]} + (p_reg[0] ? {1'b0, a_reg} : 65'd0);
        rtop     = p_reg[127:63];
        rdiff    = rtop - {1'b0, c_reg};
        ge       = (rtop >= {1'b0, c_reg});
        div_step = ge ? {rdiff[63:0], p_reg[62:0], 1'b1} : {p_reg[126:0], 1'b0};
        quo      = ovf_reg ? 64'hFFFF_FFFF_FFFF_FFFF : p_reg[63:0];
        mag      = mul_only_reg ? p_reg[63:0] : (quo >> sh_reg);
        capped   = (!mul_only_reg && (mag > MAG_CAP)) ? MAG_CAP : mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE: begin
                    if (req.start) begin
                        neg_reg      <= op_a[63];
                        a_reg        <= op_a[63] ? (64'd0 - op_a) : op_a;
                        p_reg        <= {64'd0, op_b};
                        c_reg        <= op_c;
                        sh_reg       <= req.shift;
                        mul_only_reg <= req.mul_only;
                        ovf_reg      <= 1'b0;
                        cnt_reg      <= 6'd0;
                        state_reg    <= U_MUL;
                    end
                end
                U_MUL: begin
                    p_reg   <= {mul_sum, p_reg[63:1]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= mul_only_reg ? U_POST : U_CHK;
                    end
                end
                U_CHK: begin
                    cnt_reg <= 6'd0;
                    if (p_reg[127:64] >= c_reg) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= U_POST;
                    end else begin
                        state_reg <= U_DIV;
                    end
                end
                U_DIV: begin
                    p_reg   <= div_step;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= U_POST;
                    end
                end
                U_POST: begin
                    result_reg <= neg_reg ? (64'sd0 - signed'(capped)) : signed'(capped);
                    done_reg   <= 1'b1;
                    state_reg  <= U_IDLE;
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/storage_housing_thermal_balance_top.sv =====
// The block takes one request at a time.
// Each multiply-divide pass on the shared bit-serial unit runs 64 multiply steps, then
// 64 divide steps unless the quotient overflows; a plain multiply pass runs only the
// multiply steps. These passes set the rate.
// Synchronous active-low reset restores register defaults and both room temperatures.
module storage_housing_thermal_balance_top import shtb_pkg::*; #(
    parameter logic signed [15:0] INITIAL_ROOM_TEMP = INITIAL_ROOM_TEMP_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_ambient_temp,
    input  logic [23:0]           s_step_hours,
    input  logic signed [31:0]    s_h2_heat_output,
    input  logic [39:0]           s_h2_heat_capacity,
    input  logic signed [31:0]    s_battery_heat_output,
    input  logic [39:0]           s_battery_heat_capacity,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_h2_room_temp,
    output logic signed [15:0]    m_battery_room_temp,
    output logic signed [31:0]    m_h2_required_heat,
    output logic signed [31:0]    m_battery_required_heat,
    output logic signed [31:0]    m_h2_to_battery_heat,
    output logic signed [31:0]    m_remaining_heat,
    output logic signed [31:0]    m_external_heating,
    output logic signed [31:0]    m_storage_load
);

    typedef enum logic [2:0] {S_IDLE, S_MCP, S_ISSUE, S_WAIT, S_NEXT, S_REM, S_DONE} state_t;
    typedef enum logic [2:0] {OP_LOSS, OP_NETDT, OP_DTEMP, OP_TERM, OP_REQ, OP_XFER,
                              OP_EXT} op_t;

    state_t state_reg;
    op_t    op_reg;

    logic [31:0]        wall_g_reg;
    logic [39:0]        air_cap_reg;
    logic signed [15:0] h2_min_reg, h2_max_reg, bat_min_reg, bat_max_reg;
    logic [16:0]        xfer_eff_reg, heat_eff_reg;

    logic signed [15:0] h2_temp_reg, bat_temp_reg;

    logic signed [15:0] amb_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] h2_gen_reg, bat_gen_reg;
    logic [39:0]        h2_cap_reg, bat_cap_reg;

    logic               hsel_reg;
    logic [55:0]        mcpk_reg;
    logic signed [63:0] loss_reg, nd_reg, sacc_reg;
    logic signed [15:0] tnew_reg;
    logic signed [31:0] q_cur_reg, q_h2_reg, q_bat_reg, xfer_reg, rem_reg, ext_reg, load_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_h2_temp_reg, m_bat_temp_reg;
    logic signed [31:0] m_q_h2_reg, m_q_bat_reg, m_xfer_reg, m_rem_reg, m_ext_reg, m_load_reg;

    logic signed [15:0] t_old, lim_lo, lim_hi;
    logic signed [63:0] gen64;
    logic [39:0]        cap_sel;
    logic [40:0]        mcp;
    logic [55:0]        mcpk;
    logic signed [63:0] t_chk;
    logic signed [31:0] rem_sum;

    md_req_t            md_req;
    logic signed [63:0] md_a;
    logic [63:0]        md_b, md_c;
    logic               md_done;
    logic signed [63:0] md_res;

    always_comb begin
        t_old   = hsel_reg ? bat_temp_reg : h2_temp_reg;
        lim_lo  = hsel_reg ? bat_min_reg : h2_min_reg;
        lim_hi  = hsel_reg ? bat_max_reg : h2_max_reg;
        gen64   = hsel_reg ? 64'(bat_gen_reg) : 64'(h2_gen_reg);
        cap_sel = hsel_reg ? bat_cap_reg : h2_cap_reg;
        mcp     = {1'b0, cap_sel} + {1'b0, air_cap_reg};
        if (mcp == 41'd0) begin
            mcp = 41'd1;
        end
        mcpk    = 56'(mcp) * K_NUM;
        t_chk   = 64'(t_old) + md_res;
        rem_sum = sat32(64'(q_h2_reg) + 64'(q_bat_reg));
    end

    always_comb begin
        md_req.start    = (state_reg == S_ISSUE);
        md_req.mul_only = 1'b0;
        md_req.shift    = SH_NONE;
        md_a            = 64'sd0;
        md_b            = 64'd0;
        md_c            = Q16_ONE;
        case (op_reg)
            OP_LOSS: begin
                md_a = 64'(t_old) - 64'(amb_reg);
                md_b = {32'd0, wall_g_reg};
                md_c = LOSS_DIV;
            end
            OP_NETDT: begin
                md_a            = gen64 - loss_reg;
                md_b            = {40'd0, dt_reg};
                md_req.mul_only = 1'b1;
            end
            OP_DTEMP: begin
                md_a         = nd_reg;
                md_b         = FIVE_POW_11;
                md_c         = {8'd0, mcpk_reg};
                md_req.shift = SH_DTEMP;
            end
            OP_TERM: begin
                md_a         = 64'(t_old) - 64'(tnew_reg);
                md_b         = {8'd0, mcpk_reg};
                md_c         = FIVE_POW_11;
                md_req.shift = SH_TERM;
            end
            OP_REQ: begin
                md_a = sacc_reg;
                md_b = {40'd0, dt_reg};
            end
            OP_XFER: begin
                md_a = 64'(q_bat_reg);
                md_b = {47'd0, xfer_eff_reg};
            end
            OP_EXT: begin
                md_a = 64'sd0 - 64'(rem_reg);
                md_b = {47'd0, heat_eff_reg};
            end
            default: begin
                md_a = 64'sd0;
            end
        endcase
    end

    shtb_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_a    (md_a),
        .op_b    (md_b),
        .op_c    (md_c),
        .done    (md_done),
        .result  (md_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_g_reg   <= 32'd65536;
            air_cap_reg  <= 40'd1000000;
            h2_min_reg   <= 16'sd0;
            h2_max_reg   <= 16'sd10240;
            bat_min_reg  <= 16'sd0;
            bat_max_reg  <= 16'sd10240;
            xfer_eff_reg <= 17'd65536;
            heat_eff_reg <= 17'd65536;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_WALL_G:   wall_g_reg   <= cfg_wr_data[31:0];
                REG_AIR_CAP:  air_cap_reg  <= cfg_wr_data[39:0];
                REG_H2_MIN:   h2_min_reg   <= cfg_wr_data[15:0];
                REG_H2_MAX:   h2_max_reg   <= cfg_wr_data[15:0];
                REG_BAT_MIN:  bat_min_reg  <= cfg_wr_data[15:0];
                REG_BAT_MAX:  bat_max_reg  <= cfg_wr_data[15:0];
                REG_XFER_EFF: xfer_eff_reg <= cfg_wr_data[16:0];
                REG_HEAT_EFF: heat_eff_reg <= cfg_wr_data[16:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_LOSS;
            hsel_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            h2_temp_reg  <= INITIAL_ROOM_TEMP;
            bat_temp_reg <= INITIAL_ROOM_TEMP;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        amb_reg     <= s_ambient_temp;
                        dt_reg      <= s_step_hours;
                        h2_gen_reg  <= s_h2_heat_output;
                        h2_cap_reg  <= s_h2_heat_capacity;
                        bat_gen_reg <= s_battery_heat_output;
                        bat_cap_reg <= s_battery_heat_capacity;
                        hsel_reg    <= 1'b0;
                        state_reg   <= S_MCP;
                    end
                end
                S_MCP: begin
                    mcpk_reg  <= mcpk;
                    op_reg    <= OP_LOSS;
                    state_reg <= S_ISSUE;
                end
                S_ISSUE: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (md_done) begin
                        state_reg <= S_ISSUE;
                        case (op_reg)
                            OP_LOSS: begin
                                loss_reg <= md_res;
                                op_reg   <= OP_NETDT;
                            end
                            OP_NETDT: begin
                                nd_reg <= md_res;
                                op_reg <= OP_DTEMP;
                            end
                            OP_DTEMP: begin
                                if (t_chk < 64'(lim_lo)) begin
                                    tnew_reg <= lim_lo;
                                    op_reg   <= OP_TERM;
                                end else if (t_chk > 64'(lim_hi)) begin
                                    tnew_reg <= lim_hi;
                                    op_reg   <= OP_TERM;
                                end else begin
                                    tnew_reg  <= t_chk[15:0];
                                    q_cur_reg <= 32'sd0;
                                    state_reg <= S_NEXT;
                                end
                            end
                            OP_TERM: begin
                                sacc_reg <= md_res - gen64 + loss_reg;
                                op_reg   <= OP_REQ;
                            end
                            OP_REQ: begin
                                q_cur_reg <= sat32(md_res);
                                state_reg <= S_NEXT;
                            end
                            OP_XFER: begin
                                xfer_reg  <= sat32(md_res);
                                state_reg <= S_REM;
                            end
                            OP_EXT: begin
                                ext_reg   <= sat32(md_res);
                                state_reg <= S_DONE;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_NEXT: begin
                    if (!hsel_reg) begin
                        h2_temp_reg <= tnew_reg;
                        q_h2_reg    <= q_cur_reg;
                        hsel_reg    <= 1'b1;
                        state_reg   <= S_MCP;
                    end else begin
                        bat_temp_reg <= tnew_reg;
                        q_bat_reg    <= q_cur_reg;
                        if ((q_cur_reg > 32'sd0) && (q_h2_reg < 32'sd0)) begin
                            op_reg    <= OP_XFER;
                            state_reg <= S_ISSUE;
                        end else begin
                            xfer_reg  <= 32'sd0;
                            state_reg <= S_REM;
                        end
                    end
                end
                S_REM: begin
                    rem_reg <= rem_sum;
                    if (rem_sum < 32'sd0) begin
                        load_reg  <= 32'sd0;
                        op_reg    <= OP_EXT;
                        state_reg <= S_ISSUE;
                    end else begin
                        load_reg  <= rem_sum;
                        ext_reg   <= 32'sd0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_h2_temp_reg  <= h2_temp_reg;
                        m_bat_temp_reg <= bat_temp_reg;
                        m_q_h2_reg     <= q_h2_reg;
                        m_q_bat_reg    <= q_bat_reg;
                        m_xfer_reg     <= xfer_reg;
                        m_rem_reg      <= rem_reg;
                        m_ext_reg      <= ext_reg;
                        m_load_reg     <= load_reg;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready                 = (state_reg == S_IDLE);
    assign m_valid                 = m_valid_reg;
    assign m_h2_room_temp          = m_h2_temp_reg;
    assign m_battery_room_temp     = m_bat_temp_reg;
    assign m_h2_required_heat      = m_q_h2_reg;
    assign m_battery_required_heat = m_q_bat_reg;
    assign m_h2_to_battery_heat    = m_xfer_reg;
    assign m_remaining_heat        = m_rem_reg;
    assign m_external_heating      = m_ext_reg;
    assign m_storage_load          = m_load_reg;

endmodule

// ===== bench/tb_storage_housing_thermal_balance_top.sv =====
`timescale 1ns / 100ps

module tb_storage_housing_thermal_balance_top;
    import shtb_pkg::*;

    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam longint TEMP_CAP = 64'sh4000_0000_0000_0000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

    typedef struct {
        logic signed [15:0] amb;
        logic [23:0]        dt;
        logic signed [31:0] h2_gen;
        logic [39:0]        h2_cap;
        logic signed [31:0] bat_gen;
        logic [39:0]        bat_cap;
    } step_t;

    typedef struct {
        logic signed [15:0] h2_temp;
        logic signed [15:0] bat_temp;
        logic signed [31:0] h2_req;
        logic signed [31:0] bat_req;
        logic signed [31:0] xfer;
        logic signed [31:0] remain;
        logic signed [31:0] ext_heat;
        logic signed [31:0] load;
    } balance_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [15:0]    s_ambient_temp;
    logic [23:0]           s_step_hours;
    logic signed [31:0]    s_h2_heat_output;
    logic [39:0]           s_h2_heat_capacity;
    logic signed [31:0]    s_battery_heat_output;
    logic [39:0]           s_battery_heat_capacity;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [15:0]    m_h2_room_temp;
    logic signed [15:0]    m_battery_room_temp;
    logic signed [31:0]    m_h2_required_heat;
    logic signed [31:0]    m_battery_required_heat;
    logic signed [31:0]    m_h2_to_battery_heat;
    logic signed [31:0]    m_remaining_heat;
    logic signed [31:0]    m_external_heating;
    logic signed [31:0]    m_storage_load;

    storage_housing_thermal_balance_top uut (.*);

    // mirrored configuration and room temperatures
    logic [31:0]        wall_g;
    logic [39:0]        air_cap;
    logic signed [15:0] h2_min, h2_max, bat_min, bat_max;
    logic [16:0]        xfer_eff, heat_eff;
    logic signed [15:0] h2_room, bat_room;

    step_t    pending_steps[$];
    balance_t expected_balances[$];
    step_t    held_step;
    bit       holding;
    int       send_gap, recv_gap;
    int       errors;
    longint   cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void queue_step(step_t st);
        pending_steps.insert(pending_steps.size(), st);
    endfunction

    function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] >= c) return '1;
        p = p / {64'd0, c};
        return p[63:0];
    endfunction

    function automatic longint scale_trunc(longint a, logic [63:0] b, logic [63:0] c, int sh);
        logic [63:0] m;
        bit neg;
        neg = a < 0;
        m = neg ? 64'd0 - 64'(a) : 64'(a);
        m = mul_div(m, b, c) >> sh;
        if (m > 64'(TEMP_CAP)) m = 64'(TEMP_CAP);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic void housing_step(inout logic signed [15:0] room, input longint amb,
                                         input logic [23:0] dt, input longint gen,
                                         input logic [39:0] cap, input longint lo,
                                         input longint hi, output longint q);
        longint t_old, loss, net, dtemp, t_chk, t_new, term;
        logic [63:0] mcp, mcpk;
        bit clamped;
        t_old = room;
        mcp = {24'd0, cap} + {24'd0, air_cap};
        if (mcp == 0) mcp = 1;
        mcpk = mcp * 64'(K_NUM);
        loss = scale_trunc(t_old - amb, {32'd0, wall_g}, LOSS_DIV, 0);
        net = gen - loss;
        dtemp = scale_trunc(net * longint'({40'd0, dt}), FIVE_POW_11, mcpk, 13);
        t_chk = t_old + dtemp;
        clamped = 1;
        if (t_chk < lo) t_new = lo;
        else if (t_chk > hi) t_new = hi;
        else begin
            t_new = t_chk;
            clamped = 0;
        end
        q = 0;
        if (clamped) begin
            term = scale_trunc(t_old - t_new, mcpk, FIVE_POW_11, 3);
            q = clip32(scale_trunc(term - gen + loss, {40'd0, dt}, Q16_ONE, 0));
        end
        room = t_new[15:0];
    endfunction

    function automatic balance_t predict_balance(step_t st);
        balance_t r;
        longint q_h2, q_bat, xf, rem, ext, ld;
        housing_step(h2_room, st.amb, st.dt, st.h2_gen, st.h2_cap, h2_min, h2_max, q_h2);
        housing_step(bat_room, st.amb, st.dt, st.bat_gen, st.bat_cap, bat_min, bat_max, q_bat);
        xf = 0;
        ext = 0;
        ld = 0;
        if (q_bat > 0 && q_h2 < 0) xf = clip32(scale_trunc(q_bat, {47'd0, xfer_eff}, Q16_ONE, 0));
        rem = clip32((q_h2 + xf) + (q_bat - xf));
        if (rem < 0) ext = clip32(scale_trunc(-rem, {47'd0, heat_eff}, Q16_ONE, 0));
        else ld = rem;
        r.h2_temp = h2_room;
        r.bat_temp = bat_room;
        r.h2_req = q_h2[31:0];
        r.bat_req = q_bat[31:0];
        r.xfer = xf[31:0];
        r.remain = rem[31:0];
        r.ext_heat = ext[31:0];
        r.load = ld[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver
    always @(posedge aclk) begin
        bit next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
            holding = 0;
            send_gap = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_balances.insert(expected_balances.size(), predict_balance(held_step));
                holding = 0;
                next_valid = 0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_steps.size() > 0) begin
                    held_step = pending_steps.pop_front();
                    s_ambient_temp <= held_step.amb;
                    s_step_hours <= held_step.dt;
                    s_h2_heat_output <= held_step.h2_gen;
                    s_h2_heat_capacity <= held_step.h2_cap;
                    s_battery_heat_output <= held_step.bat_gen;
                    s_battery_heat_capacity <= held_step.bat_cap;
                    next_valid = 1;
                    holding = 1;
                    send_gap = pick_gap();
                end
            end
            s_valid <= next_valid;
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            errors++;
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        balance_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_balances.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = expected_balances.pop_front();
                    check_field("h2_room_temp", 32'(e.h2_temp), 32'(m_h2_room_temp));
                    check_field("battery_room_temp", 32'(e.bat_temp), 32'(m_battery_room_temp));
                    check_field("h2_required_heat", e.h2_req, m_h2_required_heat);
                    check_field("battery_required_heat", e.bat_req, m_battery_required_heat);
                    check_field("h2_to_battery_heat", e.xfer, m_h2_to_battery_heat);
                    check_field("remaining_heat", e.remain, m_remaining_heat);
                    check_field("external_heating", e.ext_heat, m_external_heating);
                    check_field("storage_load", e.load, m_storage_load);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) < 3) recv_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v;
        case (reg_idx_t'(idx))
            REG_WALL_G:   wall_g = v[31:0];
            REG_AIR_CAP:  air_cap = v[39:0];
            REG_H2_MIN:   h2_min = v[15:0];
            REG_H2_MAX:   h2_max = v[15:0];
            REG_BAT_MIN:  bat_min = v[15:0];
            REG_BAT_MAX:  bat_max = v[15:0];
            REG_XFER_EFF: xfer_eff = v[16:0];
            REG_HEAT_EFF: heat_eff = v[16:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] g, logic [39:0] air, logic [15:0] hmin,
                              logic [15:0] hmax, logic [15:0] bmin, logic [15:0] bmax,
                              logic [16:0] xe, logic [16:0] he);
        write_reg(REG_WALL_G, g);
        write_reg(REG_AIR_CAP, air);
        write_reg(REG_H2_MIN, hmin);
        write_reg(REG_H2_MAX, hmax);
        write_reg(REG_BAT_MIN, bmin);
        write_reg(REG_BAT_MAX, bmax);
        write_reg(REG_XFER_EFF, xe);
        write_reg(REG_HEAT_EFF, he);
    endtask

    task automatic wait_idle();
        while (pending_steps.size() != 0 || holding || expected_balances.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic step_t make_step(logic [15:0] amb, logic [23:0] dt, logic [31:0] hg,
                                        logic [39:0] hc, logic [31:0] bg, logic [39:0] bc);
        step_t s;
        s.amb = amb;
        s.dt = dt;
        s.h2_gen = hg;
        s.h2_cap = hc;
        s.bat_gen = bg;
        s.bat_cap = bc;
        return s;
    endfunction

    function automatic step_t rand_step();
        step_t s;
        s.amb = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16000) - 4000);
        case ($urandom_range(0, 3))
            0: s.dt = 24'($urandom);
            1: s.dt = 24'($urandom_range(0, 255));
            default: s.dt = 24'($urandom_range(0, 65536));
        endcase
        s.h2_gen = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        s.bat_gen = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        s.h2_cap = ($urandom_range(0, 3) == 0) ? {8'($urandom), $urandom} : 40'($urandom_range(0, 20_000_000));
        s.bat_cap = ($urandom_range(0, 3) == 0) ? {8'($urandom), $urandom} : 40'($urandom_range(0, 20_000_000));
        return s;
    endfunction

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_ambient_temp = '0;
        s_step_hours = '0;
        s_h2_heat_output = '0;
        s_h2_heat_capacity = '0;
        s_battery_heat_output = '0;
        s_battery_heat_capacity = '0;
        m_ready = 1'b0;
        errors = 0;
        cycles = 0;
        holding = 0;
        wall_g = 32'd65536;
        air_cap = 40'd1000000;
        h2_min = 16'sd0;
        h2_max = 16'sd10240;
        bat_min = 16'sd0;
        bat_max = 16'sd10240;
        xfer_eff = 17'd65536;
        heat_eff = 17'd65536;
        h2_room = INITIAL_ROOM_TEMP_DEF;
        bat_room = INITIAL_ROOM_TEMP_DEF;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset configuration
        queue_step(make_step(16'sd2000, 24'd65536, 32'd0, 40'd0, 32'd0, 40'd0));
        queue_step(make_step(16'h7FFF, 24'hFFFFFF, 32'h7FFFFFFF, 40'd0,
                             32'h80000000, 40'd0));
        queue_step(make_step(16'h8000, 24'hFFFFFF, 32'h80000000, '1,
                             32'h7FFFFFFF, '1));
        queue_step(make_step(16'sd0, 24'd0, 32'd0, 40'd5, 32'd0, 40'd5));
        queue_step(make_step(16'sd0, 24'd65536, 32'hFFF00000, 40'd1000,
                             32'h00100000, 40'd1000));
        queue_step(make_step(16'sd5120, 24'd32768, 32'h00010000, 40'd500000,
                             32'hFFFF0000, 40'd500000));
        wait_idle();

        // extremes: tiny capacity, huge conductance, crossed limits, overdriven efficiencies
        set_config(32'hFFFFFFFF, 40'd1, 16'sd1000, -16'sd1000, 16'h7FFF, 16'h8000,
                   17'd131071, 17'd131071);
        write_reg(REG_SPARE_FIRST, 40'hFF);
        write_reg(REG_SPARE_LAST, '1);
        queue_step(make_step(16'h8000, 24'hFFFFFF, 32'h7FFFFFFF, 40'd0,
                             32'h7FFFFFFF, 40'd0));
        queue_step(make_step(16'h7FFF, 24'd1, 32'h80000000, 40'd0,
                             32'h00000001, 40'd0));
        queue_step(make_step(16'sd0, 24'd65536, 32'h80000000, 40'd0,
                             32'h7FFFFFFF, 40'd1));
        queue_step(make_step(16'sd0, 24'hFFFFFF, 32'hFFFF0000, '1,
                             32'h00010000, '1));
        wait_idle();

        set_config(32'd0, 40'hFFFFFFFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                   17'd0, 17'd0);
        queue_step(make_step(16'sd100, 24'd65536, 32'h7FFFFFFF, 40'd0,
                             32'h80000000, 40'd0));
        queue_step(make_step(16'h8000, 24'hFFFFFF, 32'h12345678, '1,
                             32'h87654321, '1));
        wait_idle();

        set_config(32'd131072, 40'd1000, 16'sd2560, 16'sd2560, -16'sd2560, 16'sd7680,
                   17'd65536, 17'd32768);
        queue_step(make_step(16'sd0, 24'd65536, 32'h80000000, 40'd0,
                             32'h7FFFFFFF, 40'd0));
        queue_step(make_step(16'sd0, 24'd65536, 32'hFFF00000, 40'd100,
                             32'h00100000, 40'd100));
        queue_step(make_step(16'sd0, 24'd0, 32'hFFF00000, 40'd100,
                             32'h00100000, 40'd100));
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            logic [15:0] a, b, c, d;
            a = 16'($urandom_range(0, 6000) - 3000);
            b = 16'($signed(a) + $urandom_range(0, 8000));
            c = 16'($urandom_range(0, 6000) - 3000);
            d = 16'($signed(c) + $urandom_range(0, 8000));
            if (ph % 4 == 3) begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            set_config(($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 1 << 20)),
                       ($urandom_range(0, 3) == 0) ? {8'($urandom), $urandom}
                                                   : 40'($urandom_range(1, 5_000_000)),
                       a, b, c, d, 17'($urandom_range(0, 131071)),
                       17'($urandom_range(0, 131071)));
            for (int k = 0; k < 100; k++) queue_step(rand_step());
            wait_idle();
        end

        repeat (200) @(posedge aclk);
        if (expected_balances.size() != 0) begin
            $error("%0d results never arrived", expected_balances.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/shtb_pkg.sv
hw/rtl/shtb_muldiv.sv
hw/rtl/storage_housing_thermal_balance_top.sv
bench/tb_storage_housing_thermal_balance_top.sv
